/* design/idtp_pkg.sv */
`timescale 1ns / 1ps

package idtp_pkg;

   // field widths
   localparam int unsigned POS_W   = 5;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned FIELD_W = 7;
   localparam int unsigned DAYS_W  = 23;
   localparam int unsigned SECS_W  = 17;
   localparam int unsigned VALUE_W = 39;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned CHAR_W  = 8;

   // string queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // format modes
   typedef enum logic [MODE_W-1:0] {
      MODE_DATE     = 2'd0,
      MODE_TIME     = 2'd1,
      MODE_DATETIME = 2'd2
   } mode_type;

   // register indexes
   localparam logic CSR_MIN_DAY_NUMBER = 1'b0;
   localparam logic CSR_MAX_DAY_NUMBER = 1'b1;

   localparam logic signed [DAYS_W-1:0] MIN_DAY_RESET = -23'sd719528;
   localparam logic signed [DAYS_W-1:0] MAX_DAY_RESET = 23'sd2932896;

   // calendar constants
   localparam int unsigned ERA_DAYS        = 146097;
   localparam int unsigned EPOCH_SHIFT     = 719468;
   localparam int unsigned EPOCH_OFFSET    = EPOCH_SHIFT + ERA_DAYS;
   localparam int unsigned DAYS_PER_YEAR   = 365;
   localparam int unsigned SECONDS_PER_DAY = 86400;
   localparam int unsigned SECONDS_PER_HR  = 3600;
   localparam int unsigned SECONDS_PER_MIN = 60;
   localparam int unsigned YEAR_SHIFT      = 400;

   // reciprocal of 25, exact for inputs below 4681
   localparam int unsigned RECIP_25       = 1311;
   localparam int unsigned RECIP_25_SHIFT = 15;

   // one finished string as handed from front to back
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic               shape_ok;
      logic [YEAR_W-1:0]  year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [FIELD_W-1:0] second;
   } string_rec_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
      logic                   full;
      logic                   empty;
   } queue_status_type;

   // floor(x / 25) by reciprocal multiply
   function automatic logic [6:0] div25(input logic [11:0] x);
      logic [22:0] prod;
      prod = 23'(x) * 23'(RECIP_25);
      return prod[RECIP_25_SHIFT+6:RECIP_25_SHIFT];
   endfunction

   // length of a month, zero for a month out of range
   function automatic logic [4:0] month_len(input logic [FIELD_W-1:0] month, input logic leap);
      logic [4:0] len;
      unique case (month) inside
         7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
         7'd4, 7'd6, 7'd9, 7'd11:                   len = 5'd30;
         7'd2:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

   // days before the first of a month, year counted from march
   function automatic logic [8:0] days_before_month(input logic [FIELD_W-1:0] month);
      logic [8:0] d;
      unique case (month)
         7'd3:    d = 9'd0;
         7'd4:    d = 9'd31;
         7'd5:    d = 9'd61;
         7'd6:    d = 9'd92;
         7'd7:    d = 9'd122;
         7'd8:    d = 9'd153;
         7'd9:    d = 9'd184;
         7'd10:   d = 9'd214;
         7'd11:   d = 9'd245;
         7'd12:   d = 9'd275;
         7'd1:    d = 9'd306;
         7'd2:    d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

/* design/idtp_front.sv */
`timescale 1ns / 1ps

module idtp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_mode,
   input  logic [7:0]                  req_char_code,
   input  logic                        req_last,
   input  idtp_pkg::queue_status_type  queue_status,
   output logic                        push,
   output idtp_pkg::string_rec_type    push_rec
);
   import idtp_pkg::*;

   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_DASH    = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_COLON   = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_T = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_T = 8'h74;
   localparam logic [POS_W-1:0]  POS_MAX      = '1;

   typedef enum logic [2:0] {
      SEL_NONE,
      SEL_YEAR,
      SEL_MONTH,
      SEL_DAY,
      SEL_HOUR,
      SEL_MINUTE,
      SEL_SECOND
   } field_sel_type;

   logic [POS_W-1:0]   pos_ff, pos_in, upd_pos;
   logic               failed_ff, failed_in, upd_failed;
   logic [YEAR_W-1:0]  year_ff, year_in, upd_year;
   logic [FIELD_W-1:0] month_ff, month_in, upd_month;
   logic [FIELD_W-1:0] day_ff, day_in, upd_day;
   logic [FIELD_W-1:0] hour_ff, hour_in, upd_hour;
   logic [FIELD_W-1:0] minute_ff, minute_in, upd_minute;
   logic [FIELD_W-1:0] second_ff, second_in, upd_second;

   logic               accept;
   logic               char_is_num;
   logic [CHAR_W-1:0]  digit_full;
   logic [3:0]         digit;
   logic               in_date, in_time, in_sep;
   logic [POS_W-1:0]   time_pos_full;
   logic [2:0]         time_pos;
   logic               char_good;
   field_sel_type      sel;
   logic               len_ok;

   function automatic logic [FIELD_W-1:0] push7(input logic [FIELD_W-1:0] acc,
                                               input logic [3:0] dig);
      return FIELD_W'({acc, 3'b000} + {acc, 1'b0} + FIELD_W'(dig));
   endfunction

   function automatic logic [YEAR_W-1:0] push14(input logic [YEAR_W-1:0] acc,
                                               input logic [3:0] dig);
      return YEAR_W'({acc, 3'b000} + {acc, 1'b0} + YEAR_W'(dig));
   endfunction

   assign accept    = req_valid && !queue_status.full;
   assign req_stall = queue_status.full;

   // character class
   assign char_is_num = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
   assign digit_full  = req_char_code - CHAR_ZERO;
   assign digit       = digit_full[3:0];

   // which part of the layout this position belongs to
   always_comb begin
      in_date       = 1'b0;
      in_time       = 1'b0;
      in_sep        = 1'b0;
      time_pos_full = pos_ff;
      unique case (mode_type'(req_mode))
         MODE_DATE: begin
            in_date = pos_ff < 5'd10;
         end
         MODE_TIME: begin
            in_time = pos_ff < 5'd8;
         end
         MODE_DATETIME: begin
            in_date       = pos_ff < 5'd10;
            in_sep        = pos_ff == 5'd10;
            in_time       = (pos_ff >= 5'd11) && (pos_ff < 5'd19);
            time_pos_full = pos_ff - 5'd11;
         end
         default: begin
            in_date = 1'b0;
         end
      endcase
   end

   assign time_pos = time_pos_full[2:0];

   // layout check and digit routing
   always_comb begin
      char_good = 1'b0;
      sel       = SEL_NONE;
      if (in_date) begin
         if (pos_ff == 5'd4 || pos_ff == 5'd7) begin
            char_good = req_char_code == CHAR_DASH;
         end else begin
            char_good = char_is_num;
            if (char_is_num) begin
               if (pos_ff < 5'd4) sel = SEL_YEAR;
               else if (pos_ff < 5'd7) sel = SEL_MONTH;
               else sel = SEL_DAY;
            end
         end
      end else if (in_time) begin
         if (time_pos == 3'd2 || time_pos == 3'd5) begin
            char_good = req_char_code == CHAR_COLON;
         end else begin
            char_good = char_is_num;
            if (char_is_num) begin
               if (time_pos < 3'd2) sel = SEL_HOUR;
               else if (time_pos < 3'd5) sel = SEL_MINUTE;
               else sel = SEL_SECOND;
            end
         end
      end else if (in_sep) begin
         char_good = (req_char_code == CHAR_SPACE) || (req_char_code == CHAR_UPPER_T) ||
                     (req_char_code == CHAR_LOWER_T);
      end
   end

   // state after this character
   always_comb begin
      upd_year   = year_ff;
      upd_month  = month_ff;
      upd_day    = day_ff;
      upd_hour   = hour_ff;
      upd_minute = minute_ff;
      upd_second = second_ff;
      case (sel)
         SEL_YEAR:   upd_year   = push14(year_ff, digit);
         SEL_MONTH:  upd_month  = push7(month_ff, digit);
         SEL_DAY:    upd_day    = push7(day_ff, digit);
         SEL_HOUR:   upd_hour   = push7(hour_ff, digit);
         SEL_MINUTE: upd_minute = push7(minute_ff, digit);
         SEL_SECOND: upd_second = push7(second_ff, digit);
         default:    upd_year   = year_ff;
      endcase
      upd_failed = failed_ff || !char_good;
      upd_pos    = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
   end

   // string length against the mode of the last character
   always_comb begin
      unique case (mode_type'(req_mode))
         MODE_DATE:     len_ok = upd_pos == 5'd10;
         MODE_TIME:     len_ok = (upd_pos == 5'd5) || (upd_pos == 5'd8);
         MODE_DATETIME: len_ok = (upd_pos == 5'd16) || (upd_pos == 5'd19);
         default:       len_ok = 1'b0;
      endcase
   end

   // finished string towards the queue
   assign push              = accept && req_last;
   assign push_rec.mode     = req_mode;
   assign push_rec.shape_ok = len_ok && !upd_failed;
   assign push_rec.year     = upd_year;
   assign push_rec.month    = upd_month;
   assign push_rec.day      = upd_day;
   assign push_rec.hour     = upd_hour;
   assign push_rec.minute   = upd_minute;
   assign push_rec.second   = upd_second;

   // next per-string state, cleared after the last character
   always_comb begin
      pos_in    = pos_ff;
      failed_in = failed_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      if (accept) begin
         if (req_last) begin
            pos_in    = '0;
            failed_in = 1'b0;
            year_in   = '0;
            month_in  = '0;
            day_in    = '0;
            hour_in   = '0;
            minute_in = '0;
            second_in = '0;
         end else begin
            pos_in    = upd_pos;
            failed_in = upd_failed;
            year_in   = upd_year;
            month_in  = upd_month;
            day_in    = upd_day;
            hour_in   = upd_hour;
            minute_in = upd_minute;
            second_in = upd_second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         failed_ff <= 1'b0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         failed_ff <= failed_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
      end
   end

endmodule

/* design/idtp_queue.sv */
`timescale 1ns / 1ps

module idtp_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  idtp_pkg::string_rec_type    push_rec,
   input  logic                        pop,
   output idtp_pkg::string_rec_type    head_rec,
   output idtp_pkg::queue_status_type  status
);
   import idtp_pkg::*;

   string_rec_type         entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

   assign status.count = count_ff;
   assign status.full  = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign head_rec     = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

/* design/idtp_back.sv */
`timescale 1ns / 1ps

module idtp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [22:0]                 csr_write_data,
   input  idtp_pkg::string_rec_type    head_rec,
   input  idtp_pkg::queue_status_type  queue_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_valid_res,
   output logic signed [38:0]          rsp_value
);
   import idtp_pkg::*;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic               shape_ok;
      logic               tm_ok;
      logic [SECS_W-1:0]  secs;
      logic [YEAR_W-1:0]  year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [6:0]         qy4;
      logic [6:0]         qy16;
      logic [YEAR_W-1:0]  ys;
      logic [6:0]         qys4;
      logic [6:0]         qys16;
      logic [8:0]         doy;
   } s2_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic               shape_ok;
      logic               tm_ok;
      logic               date_ok;
      logic [SECS_W-1:0]  secs;
      logic [DAYS_W-1:0]  days;
   } s3_type;

   logic signed [DAYS_W-1:0] min_day_ff, max_day_ff;

   logic            advance;
   logic            s1_valid_ff, s2_valid_ff, s3_valid_ff;
   string_rec_type  s1_ff;
   s2_type          s2_ff, s2_in;
   s3_type          s3_ff, s3_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_res_ff, rsp_valid_res_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic [YEAR_W:0]    ys_wide;
   logic [18:0]        secs_wide;
   logic [8:0]         cum_days;
   logic [11:0]        y4, ys4;
   logic [11:0]        y16, ys16;
   logic               leap;
   logic [4:0]         dim;
   logic [24:0]        days_wide;
   logic               in_bounds;
   logic [VALUE_W-1:0] days_ext;
   logic [VALUE_W-1:0] epoch;

   // whole pipe moves when the result register is free or being taken
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !queue_status.empty;

   // bound registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_day_ff <= MIN_DAY_RESET;
         max_day_ff <= MAX_DAY_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_MIN_DAY_NUMBER) min_day_ff <= csr_write_data;
         else if (csr_index == CSR_MAX_DAY_NUMBER) max_day_ff <= csr_write_data;
      end
   end

   // stage 2: shifted year, quotients by 25, day of year, time of day
   always_comb begin
      ys_wide  = (YEAR_W + 1)'(s1_ff.year) + (YEAR_W + 1)'(YEAR_SHIFT) -
                 ((s1_ff.month <= 7'd2) ? 15'd1 : 15'd0);
      y4       = s1_ff.year[YEAR_W-1:2];
      y16      = {2'b00, s1_ff.year[YEAR_W-1:4]};
      ys4      = ys_wide[YEAR_W-1:2];
      ys16     = {2'b00, ys_wide[YEAR_W-1:4]};
      cum_days = days_before_month(s1_ff.month);
      secs_wide = 19'(s1_ff.hour) * 19'(SECONDS_PER_HR) +
                  19'(s1_ff.minute) * 19'(SECONDS_PER_MIN) + 19'(s1_ff.second);

      s2_in.mode     = s1_ff.mode;
      s2_in.shape_ok = s1_ff.shape_ok;
      s2_in.tm_ok    = (s1_ff.hour <= 7'd23) && (s1_ff.minute <= 7'd59) &&
                       (s1_ff.second <= 7'd59);
      s2_in.secs     = secs_wide[SECS_W-1:0];
      s2_in.year     = s1_ff.year;
      s2_in.month    = s1_ff.month;
      s2_in.day      = s1_ff.day;
      s2_in.qy4      = div25(y4);
      s2_in.qy16     = div25(y16);
      s2_in.ys       = ys_wide[YEAR_W-1:0];
      s2_in.qys4     = div25(ys4);
      s2_in.qys16    = div25(ys16);
      s2_in.doy      = cum_days + {2'b00, s1_ff.day} - 9'd1;
   end

   // stage 3: leap rule, day within month, day count
   always_comb begin
      leap = ((s2_ff.year[1:0] == 2'b00) &&
              (12'(s2_ff.qy4) * 12'd25 != s2_ff.year[YEAR_W-1:2])) ||
             ((s2_ff.year[3:0] == 4'b0000) &&
              (12'(s2_ff.qy16) * 12'd25 == {2'b00, s2_ff.year[YEAR_W-1:4]}));
      dim  = month_len(s2_ff.month, leap);
      days_wide = 25'(s2_ff.ys) * 25'(DAYS_PER_YEAR) + 25'(s2_ff.ys[YEAR_W-1:2]) -
                  25'(s2_ff.qys4) + 25'(s2_ff.qys16) + 25'(s2_ff.doy) -
                  25'(EPOCH_OFFSET);

      s3_in.mode     = s2_ff.mode;
      s3_in.shape_ok = s2_ff.shape_ok;
      s3_in.tm_ok    = s2_ff.tm_ok;
      s3_in.date_ok  = (s2_ff.month >= 7'd1) && (s2_ff.month <= 7'd12) &&
                       (s2_ff.day >= 7'd1) && (s2_ff.day <= 7'(dim));
      s3_in.secs     = s2_ff.secs;
      s3_in.days     = days_wide[DAYS_W-1:0];
   end

   // result stage: bounds, value by mode
   always_comb begin
      in_bounds = ($signed(s3_ff.days) >= min_day_ff) && ($signed(s3_ff.days) <= max_day_ff);
      days_ext  = {{(VALUE_W - DAYS_W){s3_ff.days[DAYS_W-1]}}, s3_ff.days};
      epoch     = days_ext * VALUE_W'(SECONDS_PER_DAY) + VALUE_W'(s3_ff.secs);
      unique case (mode_type'(s3_ff.mode))
         MODE_DATE: begin
            rsp_valid_res_in = s3_ff.shape_ok && s3_ff.date_ok && in_bounds;
            rsp_value_in     = days_ext;
         end
         MODE_TIME: begin
            rsp_valid_res_in = s3_ff.shape_ok && s3_ff.tm_ok;
            rsp_value_in     = VALUE_W'(s3_ff.secs);
         end
         MODE_DATETIME: begin
            rsp_valid_res_in = s3_ff.shape_ok && s3_ff.date_ok && in_bounds && s3_ff.tm_ok;
            rsp_value_in     = epoch;
         end
         default: begin
            rsp_valid_res_in = 1'b0;
            rsp_value_in     = '0;
         end
      endcase
      if (!rsp_valid_res_in) rsp_value_in = '0;
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !queue_status.empty;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff            <= head_rec;
         s2_ff            <= s2_in;
         s3_ff            <= s3_in;
         rsp_valid_res_ff <= rsp_valid_res_in;
         rsp_value_ff     <= rsp_value_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;
   assign rsp_value     = $signed(rsp_value_ff);

endmodule

/* design/iso_datetime_text_parser_core.sv */
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_mode[1:0] req_char_code[7:0] req_last
// rsp       out        rsp_valid/rsp_stall   rsp_valid_res rsp_value[38:0] signed
// csr       in         csr_write_enable      csr_index csr_write_data[22:0]
//
// One character is taken every cycle while req_stall is low; each string gives one result
// after its last character. The string then passes the queue, an input register, two
// arithmetic stages (year quotients, then day count) and a stage for bound check and x86400.
// A four-entry string queue sits between the character front and the arithmetic pipe, so
// characters keep flowing while rsp_stall holds; req_stall rises only when the queue is full.
// Synchronous reset clears string state, queue and pipe, and opens the day bounds fully.

module iso_datetime_text_parser_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [7:0]          req_char_code,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_valid_res,
   output logic signed [38:0]  rsp_value,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [22:0]         csr_write_data
);
   import idtp_pkg::*;

   queue_status_type queue_status;
   string_rec_type   push_rec;
   string_rec_type   head_rec;
   logic             push;
   logic             pop;

   // character front
   idtp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_char_code (req_char_code),
      .req_last      (req_last),
      .queue_status  (queue_status),
      .push          (push),
      .push_rec      (push_rec)
   );

   // finished strings waiting for the back
   idtp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .status   (queue_status)
   );

   // range checks and conversion
   idtp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .head_rec         (head_rec),
      .queue_status     (queue_status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_value        (rsp_value)
   );

   // a failed string reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_value == '0)
      else $error("invalid result with non-zero value");

   // a finished string is held in the queue on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      push |=> !queue_status.empty)
      else $error("finished string lost from queue");

   // fill count stays within the depth
   assert property (@(posedge clock) disable iff (reset)
      queue_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   // back never takes from an empty queue
   assert property (@(posedge clock) disable iff (reset)
      !(pop && queue_status.empty))
      else $error("pop from empty queue");

endmodule
